// ----- hdl/box_overlap_suppression_defines.svh -----
// assertion macros for the box overlap suppression block
// expects a clock named clk and a synchronous reset named rst in the using module
`ifndef BOX_OVERLAP_SUPPRESSION_DEFINES_SVH
`define BOX_OVERLAP_SUPPRESSION_DEFINES_SVH

// property checked every cycle outside reset
`define BOS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in one cycle implies a result in the next
`define BOS_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- hdl/bos_pkg.sv -----
// shared types and constants for the box overlap suppression block
// no dependencies
`default_nettype none

package bos_pkg;

  localparam int FIELD_W    = 16;
  localparam int THR_W      = 17;
  localparam int FRAC_SHIFT = 16;
  localparam logic [THR_W-1:0] THR_RESET = 17'd32768;

  typedef enum logic [1:0] {
    S_IDLE,
    S_AREA,
    S_SCAN,
    S_RESULT
  } bos_state_t;

  typedef struct packed {
    logic valid;
    logic flush;
  } bos_cmp_ctrl_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } bos_cmp_stat_t;

endpackage

`default_nettype wire

// ----- hdl/bos_store.sv -----
// kept box store: one write port, one registered read port
// depends on nothing but its parameters
`default_nettype none

module bos_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 97
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bos_iou_unit.sv -----
// pipelined overlap compare: one kept box against the new box per cycle
// depends on bos_pkg
`default_nettype none

module bos_iou_unit
  import bos_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire bos_cmp_ctrl_t         ctrl,
  input  wire logic [THR_W-1:0]      thr,
  input  wire logic [CW-1:0]         kl,
  input  wire logic [CW-1:0]         kt,
  input  wire logic [CW-1:0]         kr,
  input  wire logic [CW-1:0]         kb,
  input  wire logic [2*CW:0]         karea,
  input  wire logic [CW-1:0]         bl,
  input  wire logic [CW-1:0]         bt,
  input  wire logic [CW-1:0]         br,
  input  wire logic [CW-1:0]         bb,
  input  wire logic [2*CW:0]         barea,
  output bos_cmp_stat_t              stat
);

  localparam int AREAW = 2 * CW + 1;
  localparam int UNIW  = AREAW + 1;
  localparam int PW    = THR_W + UNIW;

  logic [CW-1:0]     x1, y1, x2, y2;
  logic [CW:0]       sw, sh;
  logic [AREAW-1:0]  inter_prod;
  logic [UNIW-1:0]   uni;
  logic [PW-1:0]     rhs_prod;

  logic              va;
  logic [AREAW-1:0]  inter_a;
  logic [UNIW-1:0]   sum_a;
  logic              vb;
  logic              zero_b;
  logic [PW-1:0]     lhs_b;
  logic [PW-1:0]     rhs_b;

  // intersection corners and spans
  always_comb begin
    x1 = (kl > bl) ? kl : bl;
    y1 = (kt > bt) ? kt : bt;
    x2 = (kr < br) ? kr : br;
    y2 = (kb < bb) ? kb : bb;
    sw = (x2 >= x1) ? ({1'b0, x2} - {1'b0, x1} + 1'b1) : '0;
    sh = (y2 >= y1) ? ({1'b0, y2} - {1'b0, y1} + 1'b1) : '0;
    inter_prod = AREAW'(sw) * AREAW'(sh);
    uni = sum_a - {1'b0, inter_a};
    rhs_prod = PW'(thr) * PW'(uni);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= ctrl.valid && !ctrl.flush;
      vb <= va && !ctrl.flush;
    end
  end

  always_ff @(posedge clk) begin
    inter_a <= inter_prod;
    sum_a   <= {1'b0, karea} + {1'b0, barea};
    zero_b  <= (uni == '0);
    lhs_b   <= PW'(inter_a) << FRAC_SHIFT;
    rhs_b   <= rhs_prod;
  end

  assign stat.busy = va || vb;
  assign stat.hit  = vb && !zero_b && (lhs_b >= rhs_b);

endmodule

`default_nettype wire

// ----- hdl/box_overlap_suppression.sv -----
// greedy non-maximum suppression top level: sequencer, kept box store and compare unit
// depends on bos_pkg, bos_store, bos_iou_unit and box_overlap_suppression_defines.svh
//
//  channel | handshake              | payload
//  in      | in_valid / in_stall    | first_box, left, top, right, bottom
//  out     | out_valid / out_stall  | keep, store_overflow
//  cfg     | cfg_valid / cfg_ready  | cfg_data (overlap threshold, unsigned Q1.16)
//
// a box is taken only in idle; the sequencer computes its area, issues one kept box per
// cycle into the store read port until a suppressing match, drains the read and compare
// pipeline, loads the result once the output register is free, then returns to idle
// a suppressing match ends the scan as it leaves the compare pipeline and stops issue
// reset clears the sequencer and the kept count and sets the threshold to its default;
// the store is not cleared; a stalled result waits in the output register; the next box is taken meanwhile
`default_nettype none
`include "box_overlap_suppression_defines.svh"

module box_overlap_suppression
  import bos_pkg::*;
#(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               first_box,
  input  wire logic [FIELD_W-1:0] left,
  input  wire logic [FIELD_W-1:0] top,
  input  wire logic [FIELD_W-1:0] right,
  input  wire logic [FIELD_W-1:0] bottom,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    keep,
  output logic                    store_overflow,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [THR_W-1:0]   cfg_data
);

  localparam int CW    = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int AREAW = 2 * CW + 1;
  localparam int ENTW  = 4 * CW + AREAW;
  localparam int AW    = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNTW  = $clog2(MAX_KEPT + 1);
  localparam logic [CNTW-1:0] KEPT_FULL = CNTW'(MAX_KEPT);

  bos_state_t       state, state_next;
  logic [THR_W-1:0] thr;
  logic [CW-1:0]    bl, bt, br, bb;
  logic [AREAW-1:0] box_area;
  logic [CNTW-1:0]  kept_count;
  logic [CNTW-1:0]  issue_idx;
  logic             rd_valid;
  logic             keep_r, keep_next;

  logic             in_xfer;
  logic             out_free;
  logic             issue;
  logic             scan_done;
  logic             result_load;
  logic             store_wr;
  logic [CW:0]      box_w, box_h;
  logic [AREAW-1:0] box_prod;
  logic [ENTW-1:0]  rd_data;

  bos_cmp_ctrl_t    cmp_ctrl;
  bos_cmp_stat_t    cmp_stat;

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign box_w    = (br >= bl) ? ({1'b0, br} - {1'b0, bl} + 1'b1) : '0;
  assign box_h    = (bb >= bt) ? ({1'b0, bb} - {1'b0, bt} + 1'b1) : '0;
  assign box_prod = AREAW'(box_w) * AREAW'(box_h);

  assign cmp_ctrl.valid = rd_valid;
  assign cmp_ctrl.flush = cmp_stat.hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    keep_next   = keep_r;
    issue       = 1'b0;
    scan_done   = 1'b0;
    result_load = 1'b0;
    store_wr    = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_AREA;
        end
      end
      S_AREA: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        issue     = (issue_idx < kept_count) && !cmp_stat.hit;
        scan_done = (issue_idx == kept_count) && !rd_valid && !cmp_stat.busy;
        if (cmp_stat.hit) begin
          keep_next  = 1'b0;
          state_next = S_RESULT;
        end else if (scan_done) begin
          keep_next  = 1'b1;
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          result_load = 1'b1;
          store_wr    = keep_r && (kept_count < KEPT_FULL);
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thr        <= THR_RESET;
      kept_count <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        thr <= cfg_data;
      end
      rd_valid <= issue;
      if (in_xfer && first_box) begin
        kept_count <= '0;
      end else if (store_wr) begin
        kept_count <= kept_count + 1'b1;
      end
      if (result_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      bl <= left[CW-1:0];
      bt <= top[CW-1:0];
      br <= right[CW-1:0];
      bb <= bottom[CW-1:0];
    end
    if (state == S_AREA) begin
      box_area  <= box_prod;
      issue_idx <= '0;
    end else if (issue) begin
      issue_idx <= issue_idx + 1'b1;
    end
    keep_r <= keep_next;
    if (result_load) begin
      keep           <= keep_r;
      store_overflow <= keep_r && (kept_count >= KEPT_FULL);
    end
  end

  bos_store #(
    .DEPTH (MAX_KEPT),
    .AW    (AW),
    .DW    (ENTW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (kept_count[AW-1:0]),
    .wr_data ({bl, bt, br, bb, box_area}),
    .rd_en   (issue),
    .rd_addr (issue_idx[AW-1:0]),
    .rd_data (rd_data)
  );

  bos_iou_unit #(
    .CW (CW)
  ) u_iou (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cmp_ctrl),
    .thr   (thr),
    .kl    (rd_data[AREAW+4*CW-1 -: CW]),
    .kt    (rd_data[AREAW+3*CW-1 -: CW]),
    .kr    (rd_data[AREAW+2*CW-1 -: CW]),
    .kb    (rd_data[AREAW+CW-1 -: CW]),
    .karea (rd_data[AREAW-1:0]),
    .bl    (bl),
    .bt    (bt),
    .br    (br),
    .bb    (bb),
    .barea (box_area),
    .stat  (cmp_stat)
  );

  `BOS_ASSERT(a_count_bound, kept_count <= KEPT_FULL, "kept count beyond store depth")
  `BOS_ASSERT_NEXT(a_accept_area, in_xfer, state == S_AREA, "accepted box did not start")
  `BOS_ASSERT(a_result_src, $rose(out_valid) |-> ($past(state) == S_RESULT), "stray result")
  `BOS_ASSERT(a_overflow_keep, (out_valid && store_overflow) |-> keep, "overflow on drop")

endmodule

`default_nettype wire
